/* hw/rtl/lbs_pkg.sv */
// ----------------------------------------------------------------------------
// lbs_pkg
// Shared types, register indexes and reset values for the link bring-up
// supervisor.
// ----------------------------------------------------------------------------
package lbs_pkg;

    localparam int CFG_IDX_W = 3;

    localparam logic [CFG_IDX_W-1:0] CFG_INITIAL_LINK_WAIT   = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_RECONNECT_LINK_WAIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TIME_SYNC_WAIT      = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_BROKER_RETRY_WAIT   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_MAX_LINK_FAILURES   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_ANNOUNCE_INTERVAL   = 3'd5;

    localparam logic [31:0] RST_INITIAL_LINK_WAIT   = 32'd10000000;
    localparam logic [31:0] RST_RECONNECT_LINK_WAIT = 32'd5000000;
    localparam logic [31:0] RST_TIME_SYNC_WAIT      = 32'd10000000;
    localparam logic [31:0] RST_BROKER_RETRY_WAIT   = 32'd2000000;
    localparam logic [7:0]  RST_MAX_LINK_FAILURES   = 8'd3;
    localparam logic [31:0] RST_ANNOUNCE_INTERVAL   = 32'd3600 * 32'd1000;

    typedef enum logic [3:0] {
        ST_INIT       = 4'd0,
        ST_LINKING    = 4'd1,
        ST_LINKED     = 4'd2,
        ST_REQTIME    = 4'd3,
        ST_SETTIME    = 4'd4,
        ST_FWCHECK    = 4'd5,
        ST_LINKREADY  = 4'd6,
        ST_BROKERING  = 4'd7,
        ST_BROKERWAIT = 4'd8,
        ST_BROKERUP   = 4'd9,
        ST_READY      = 4'd10,
        ST_DOWN       = 4'd11
    } t_state;

    typedef struct packed {
        logic [31:0] now_us;
        logic [31:0] now_ms;
        logic        link_up;
        logic        link_needs_reinit;
        logic        broker_up;
        logic        time_synced;
        logic        queue_flush_ok;
    } t_in_word;

    typedef struct packed {
        logic [3:0] conn_state;
        logic       do_link_restart;
        logic       do_link_reconnect;
        logic       do_link_announce;
        logic       do_time_request;
        logic       do_firmware_check;
        logic       do_broker_begin;
        logic       do_publish_announcements;
        logic       do_announce_ready;
        logic       do_service_queues;
    } t_out_word;

    typedef struct packed {
        logic [31:0] initial_link_wait_us;
        logic [31:0] reconnect_link_wait_us;
        logic [31:0] time_sync_wait_us;
        logic [31:0] broker_retry_wait_us;
        logic [7:0]  max_link_failures;
        logic [31:0] announce_interval_ms;
    } t_cfg;

    typedef struct packed {
        t_state      state;
        logic [31:0] active_link_wait;
        logic [7:0]  link_failures;
        logic [31:0] link_start_us;
        logic [31:0] time_request_us;
        logic [31:0] broker_start_us;
        logic [31:0] last_announce_ms;
    } t_ctx;

endpackage

/* hw/rtl/link_bringup_supervisor_unit.sv */
// ----------------------------------------------------------------------------
// link_bringup_supervisor_unit
// Path: an accepted poll word passes the input register, then the result
// register. Throughput: one poll per cycle unless the output stalls; the
// state loop closes through a single step of compare and subtract logic.
// Reset: synchronous active-low; state goes to init, timers and counters
// clear, configuration returns to default waits.
// ----------------------------------------------------------------------------
module link_bringup_supervisor_unit (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  lbs_pkg::t_in_word             i_in_data,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output lbs_pkg::t_out_word            o_out_data,
    input  logic                          i_cfg_we,
    input  logic [lbs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]                   i_cfg_wdata
);
    import lbs_pkg::*;

    t_cfg      cfg;
    t_ctx      r_ctx;
    t_ctx      n_ctx;
    t_in_word  r_in;
    logic      r_in_valid;
    t_out_word r_out;
    t_out_word n_out;
    logic      r_out_valid;
    logic      advance;
    logic      load;

    lbs_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    lbs_step u_step (
        .i_ctx (r_ctx),
        .i_cfg (cfg),
        .i_in  (r_in),
        .o_ctx (n_ctx),
        .o_out (n_out)
    );

    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign load       = !r_in_valid || advance;
    assign o_in_stall = !load;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (load) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load && i_in_valid) begin
            r_in <= i_in_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ctx.state            <= ST_INIT;
            r_ctx.active_link_wait <= RST_INITIAL_LINK_WAIT;
            r_ctx.link_failures    <= 8'd0;
            r_ctx.link_start_us    <= 32'd0;
            r_ctx.time_request_us  <= 32'd0;
            r_ctx.broker_start_us  <= 32'd0;
            r_ctx.last_announce_ms <= 32'd0;
        end else if (advance) begin
            r_ctx <= n_ctx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

endmodule

/* hw/rtl/lbs_cfg_regs.sv */
// ----------------------------------------------------------------------------
// lbs_cfg_regs
// Configuration register file, written by index, reset to default waits.
// ----------------------------------------------------------------------------
module lbs_cfg_regs (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [lbs_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [31:0]                   i_cfg_wdata,
    output lbs_pkg::t_cfg                 o_cfg
);
    import lbs_pkg::*;

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.initial_link_wait_us   <= RST_INITIAL_LINK_WAIT;
            r_cfg.reconnect_link_wait_us <= RST_RECONNECT_LINK_WAIT;
            r_cfg.time_sync_wait_us      <= RST_TIME_SYNC_WAIT;
            r_cfg.broker_retry_wait_us   <= RST_BROKER_RETRY_WAIT;
            r_cfg.max_link_failures      <= RST_MAX_LINK_FAILURES;
            r_cfg.announce_interval_ms   <= RST_ANNOUNCE_INTERVAL;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_INITIAL_LINK_WAIT:   r_cfg.initial_link_wait_us   <= i_cfg_wdata;
                CFG_RECONNECT_LINK_WAIT: r_cfg.reconnect_link_wait_us <= i_cfg_wdata;
                CFG_TIME_SYNC_WAIT:      r_cfg.time_sync_wait_us      <= i_cfg_wdata;
                CFG_BROKER_RETRY_WAIT:   r_cfg.broker_retry_wait_us   <= i_cfg_wdata;
                CFG_MAX_LINK_FAILURES:   r_cfg.max_link_failures      <= i_cfg_wdata[7:0];
                CFG_ANNOUNCE_INTERVAL:   r_cfg.announce_interval_ms   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* hw/rtl/lbs_step.sv */
// ----------------------------------------------------------------------------
// lbs_step
// One poll of the supervisor: next state, stored times and action strobes.
// ----------------------------------------------------------------------------
module lbs_step (
    input  lbs_pkg::t_ctx      i_ctx,
    input  lbs_pkg::t_cfg      i_cfg,
    input  lbs_pkg::t_in_word  i_in,
    output lbs_pkg::t_ctx      o_ctx,
    output lbs_pkg::t_out_word o_out
);
    import lbs_pkg::*;

    logic [31:0] link_elapsed;
    logic [31:0] time_elapsed;
    logic [31:0] broker_elapsed;
    logic [31:0] announce_elapsed;
    logic [8:0]  fail_inc;
    logic        link_timeout;
    logic        time_timeout;
    logic        broker_retry;
    logic        announce_due;
    t_ctx        n_ctx;

    assign link_elapsed     = i_in.now_us - i_ctx.link_start_us;
    assign time_elapsed     = i_in.now_us - i_ctx.time_request_us;
    assign broker_elapsed   = i_in.now_us - i_ctx.broker_start_us;
    assign announce_elapsed = i_in.now_ms - i_ctx.last_announce_ms;
    assign fail_inc         = {1'b0, i_ctx.link_failures} + 9'd1;
    assign link_timeout     = link_elapsed > i_ctx.active_link_wait;
    assign time_timeout     = time_elapsed > i_cfg.time_sync_wait_us;
    assign broker_retry     = broker_elapsed >= i_cfg.broker_retry_wait_us;
    assign announce_due     = (i_ctx.last_announce_ms == 32'd0) ||
                              (announce_elapsed > i_cfg.announce_interval_ms);

    always_comb begin
        n_ctx = i_ctx;
        case (i_ctx.state)
            ST_LINKING: begin
                if (i_in.link_up) begin
                    n_ctx.state         = ST_LINKED;
                    n_ctx.link_failures = 8'd0;
                end else if (link_timeout) begin
                    if (fail_inc > {1'b0, i_cfg.max_link_failures}) begin
                        n_ctx.state         = ST_INIT;
                        n_ctx.link_failures = 8'd0;
                    end else begin
                        n_ctx.state         = ST_DOWN;
                        n_ctx.link_failures = fail_inc[7:0];
                    end
                end
            end
            ST_LINKED: begin
                if (i_in.link_needs_reinit) begin
                    n_ctx.state = ST_INIT;
                end else if (!i_in.link_up) begin
                    n_ctx.state = ST_DOWN;
                end else begin
                    n_ctx.state         = ST_REQTIME;
                    n_ctx.link_failures = 8'd0;
                end
            end
            ST_REQTIME: begin
                if (i_in.time_synced) begin
                    n_ctx.state = ST_FWCHECK;
                end else begin
                    n_ctx.state           = ST_SETTIME;
                    n_ctx.time_request_us = i_in.now_us;
                end
            end
            ST_SETTIME: begin
                if (!i_in.link_up) begin
                    n_ctx.state = ST_DOWN;
                end else if (i_in.time_synced) begin
                    n_ctx.state = ST_FWCHECK;
                end else if (time_timeout) begin
                    n_ctx.state = ST_LINKED;
                end
            end
            ST_FWCHECK: begin
                n_ctx.state = ST_LINKREADY;
            end
            ST_LINKREADY: begin
                if (i_in.link_up) begin
                    n_ctx.state           = ST_BROKERING;
                    n_ctx.broker_start_us = i_in.now_us;
                end else begin
                    n_ctx.state = ST_DOWN;
                end
            end
            ST_BROKERING: begin
                n_ctx.state = i_in.broker_up ? ST_BROKERUP : ST_BROKERWAIT;
            end
            ST_BROKERWAIT: begin
                if (broker_retry) begin
                    n_ctx.state = ST_LINKREADY;
                end
            end
            ST_BROKERUP: begin
                if (!i_in.broker_up) begin
                    n_ctx.state = ST_LINKREADY;
                end else begin
                    n_ctx.state = ST_READY;
                    if (announce_due) begin
                        n_ctx.last_announce_ms = i_in.now_ms;
                    end
                end
            end
            ST_READY: begin
                if (!i_in.link_up) begin
                    n_ctx.state = ST_DOWN;
                end else if (!i_in.broker_up) begin
                    n_ctx.state = ST_LINKREADY;
                end
            end
            ST_DOWN: begin
                n_ctx.state            = ST_LINKING;
                n_ctx.active_link_wait = i_cfg.reconnect_link_wait_us;
            end
            default: begin
                n_ctx.state            = ST_LINKING;
                n_ctx.active_link_wait = i_cfg.initial_link_wait_us;
                n_ctx.link_start_us    = i_in.now_us;
            end
        endcase
    end

    always_comb begin
        o_out            = '0;
        o_out.conn_state = n_ctx.state;
        case (i_ctx.state)
            ST_LINKING:    o_out.do_link_announce  = i_in.link_up;
            ST_LINKED:     ;
            ST_REQTIME:    o_out.do_time_request   = !i_in.time_synced;
            ST_SETTIME:    ;
            ST_FWCHECK:    o_out.do_firmware_check = 1'b1;
            ST_LINKREADY:  o_out.do_broker_begin   = i_in.link_up;
            ST_BROKERING:  ;
            ST_BROKERWAIT: ;
            ST_BROKERUP: begin
                o_out.do_publish_announcements = i_in.broker_up && announce_due;
                o_out.do_announce_ready        = i_in.broker_up;
            end
            ST_READY: begin
                o_out.do_service_queues = i_in.link_up && i_in.broker_up &&
                                          i_in.queue_flush_ok;
            end
            ST_DOWN:       o_out.do_link_reconnect = 1'b1;
            default:       o_out.do_link_restart   = 1'b1;
        endcase
    end

    assign o_ctx = n_ctx;

endmodule

/* tb/sv/tb_link_bringup_supervisor_unit.sv */
// ----------------------------------------------------------------------------
// tb_link_bringup_supervisor_unit
// Self-checking bench for the link bring-up supervisor. A directed table of
// polls walks the states and the timeout edges. Random polls then run under
// six register settings, with the clocks tracked so that timeouts land on
// their edges. Both sides stall in bursts, and each result word is compared
// with a local model of the supervisor or with the expected word of its table row.
// ----------------------------------------------------------------------------
module tb_link_bringup_supervisor_unit;
    timeunit 1ns;
    timeprecision 1ps;

    import lbs_pkg::*;

    localparam int QUIET_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 4;
    localparam int HOLD_CYCLES  = 64;

    localparam logic [CFG_IDX_W-1:0] CFG_IDX_SPARE = 3'd7;

    localparam logic [4:0] F_NONE   = 5'b00000;
    localparam logic [4:0] F_LINK   = 5'b10000;
    localparam logic [4:0] F_REINIT = 5'b01000;
    localparam logic [4:0] F_BROKER = 5'b00100;
    localparam logic [4:0] F_SYNCED = 5'b00010;
    localparam logic [4:0] F_FLUSH  = 5'b00001;

    localparam logic [8:0] DO_NONE      = 9'b000000000;
    localparam logic [8:0] DO_RESTART   = 9'b100000000;
    localparam logic [8:0] DO_RECONNECT = 9'b010000000;
    localparam logic [8:0] DO_ANNOUNCE  = 9'b001000000;
    localparam logic [8:0] DO_PUBLISH   = 9'b000000100;
    localparam logic [8:0] DO_READY     = 9'b000000010;
    localparam logic [8:0] DO_SERVICE   = 9'b000000001;

    typedef struct {
        t_in_word  w;
        bit        typed;
        t_out_word want;
    } t_row;

    typedef struct {
        bit        typed;
        t_out_word want;
    } t_tag;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_stall;
    t_in_word             i_in_data   = '0;
    logic                 o_out_valid;
    logic                 i_out_stall = 1'b0;
    t_out_word            o_out_data;
    logic                 i_cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] i_cfg_idx   = '0;
    logic [31:0]          i_cfg_wdata = '0;

    t_cfg        sup_cfg;
    t_ctx        sup_ctx;
    t_out_word   want_q[$];
    t_tag        pend_q[$];
    t_row        dir_tbl[$];
    logic [31:0] clk_us = '0;
    logic [31:0] clk_ms = '0;
    int          link_pct  = 90;
    int          noise_pct = 10;
    bit          idle_on   = 1'b1;
    bit          hold_long = 1'b0;
    int          errors    = 0;
    int          quiet_cycles = 0;

    link_bringup_supervisor_unit uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata)
    );

    always #5ns i_clk = ~i_clk;

    function automatic t_out_word supervise_poll(input t_in_word w);
        t_out_word   r;
        t_state      nxt;
        logic [8:0]  fails_next;
        logic [31:0] elapsed;
        r = '0;
        nxt = sup_ctx.state;
        case (sup_ctx.state)
            ST_LINKING: begin
                elapsed = w.now_us - sup_ctx.link_start_us;
                fails_next = {1'b0, sup_ctx.link_failures} + 9'd1;
                if (w.link_up) begin
                    nxt = ST_LINKED;
                    sup_ctx.link_failures = '0;
                    r.do_link_announce = 1'b1;
                end else if (elapsed > sup_ctx.active_link_wait) begin
                    if (fails_next > {1'b0, sup_cfg.max_link_failures}) begin
                        nxt = ST_INIT;
                        sup_ctx.link_failures = '0;
                    end else begin
                        sup_ctx.link_failures = fails_next[7:0];
                        nxt = ST_DOWN;
                    end
                end
            end
            ST_LINKED: begin
                if (w.link_needs_reinit) begin
                    nxt = ST_INIT;
                end else if (!w.link_up) begin
                    nxt = ST_DOWN;
                end else begin
                    nxt = ST_REQTIME;
                    sup_ctx.link_failures = '0;
                end
            end
            ST_REQTIME: begin
                if (w.time_synced) begin
                    nxt = ST_FWCHECK;
                end else begin
                    r.do_time_request = 1'b1;
                    nxt = ST_SETTIME;
                    sup_ctx.time_request_us = w.now_us;
                end
            end
            ST_SETTIME: begin
                elapsed = w.now_us - sup_ctx.time_request_us;
                if (!w.link_up) begin
                    nxt = ST_DOWN;
                end else if (w.time_synced) begin
                    nxt = ST_FWCHECK;
                end else if (elapsed > sup_cfg.time_sync_wait_us) begin
                    nxt = ST_LINKED;
                end
            end
            ST_FWCHECK: begin
                r.do_firmware_check = 1'b1;
                nxt = ST_LINKREADY;
            end
            ST_LINKREADY: begin
                if (w.link_up) begin
                    nxt = ST_BROKERING;
                    sup_ctx.broker_start_us = w.now_us;
                    r.do_broker_begin = 1'b1;
                end else begin
                    nxt = ST_DOWN;
                end
            end
            ST_BROKERING: begin
                nxt = w.broker_up ? ST_BROKERUP : ST_BROKERWAIT;
            end
            ST_BROKERWAIT: begin
                elapsed = w.now_us - sup_ctx.broker_start_us;
                if (elapsed >= sup_cfg.broker_retry_wait_us) nxt = ST_LINKREADY;
            end
            ST_BROKERUP: begin
                elapsed = w.now_ms - sup_ctx.last_announce_ms;
                if (!w.broker_up) begin
                    nxt = ST_LINKREADY;
                end else begin
                    if (sup_ctx.last_announce_ms == '0 ||
                        elapsed > sup_cfg.announce_interval_ms) begin
                        r.do_publish_announcements = 1'b1;
                        sup_ctx.last_announce_ms = w.now_ms;
                    end
                    r.do_announce_ready = 1'b1;
                    nxt = ST_READY;
                end
            end
            ST_READY: begin
                if (!w.link_up) begin
                    nxt = ST_DOWN;
                end else if (!w.broker_up) begin
                    nxt = ST_LINKREADY;
                end else begin
                    r.do_service_queues = w.queue_flush_ok;
                end
            end
            ST_DOWN: begin
                nxt = ST_LINKING;
                sup_ctx.active_link_wait = sup_cfg.reconnect_link_wait_us;
                r.do_link_reconnect = 1'b1;
            end
            default: begin
                r.do_link_restart = 1'b1;
                nxt = ST_LINKING;
                sup_ctx.active_link_wait = sup_cfg.initial_link_wait_us;
                sup_ctx.link_start_us = w.now_us;
            end
        endcase
        sup_ctx.state = nxt;
        r.conn_state = nxt;
        return r;
    endfunction

    function automatic t_in_word poll(input logic [31:0] us, input logic [31:0] ms,
                                      input logic [4:0] flags);
        return {us, ms, flags};
    endfunction

    function automatic t_out_word result(input t_state s, input logic [8:0] strobes);
        return {s, strobes};
    endfunction

    // Track the clocks; aim a share of the polls at the timeout edges.
    function automatic t_in_word random_poll();
        t_in_word w;
        int       pick;
        if ($urandom_range(0, 99) < noise_pct) begin
            w = {$urandom, $urandom, 5'($urandom)};
            return w;
        end
        pick = $urandom_range(0, 9);
        case (pick)
            4: clk_us = sup_ctx.link_start_us + sup_ctx.active_link_wait
                        + $urandom_range(0, 2) - 1;
            5: clk_us = sup_ctx.time_request_us + sup_cfg.time_sync_wait_us
                        + $urandom_range(0, 2) - 1;
            6: clk_us = sup_ctx.broker_start_us + sup_cfg.broker_retry_wait_us
                        + $urandom_range(0, 2) - 1;
            7: clk_us = clk_us + $urandom;
            default: clk_us = clk_us + $urandom_range(0, 3000);
        endcase
        pick = $urandom_range(0, 9);
        case (pick)
            0: clk_ms = '0;
            1: clk_ms = sup_ctx.last_announce_ms + sup_cfg.announce_interval_ms
                        + $urandom_range(0, 2) - 1;
            2: clk_ms = clk_ms + $urandom;
            default: clk_ms = clk_ms + $urandom_range(0, 500);
        endcase
        w.now_us            = clk_us;
        w.now_ms            = clk_ms;
        w.link_up           = ($urandom_range(0, 99) < link_pct);
        w.link_needs_reinit = ($urandom_range(0, 19) == 0);
        w.broker_up         = ($urandom_range(0, 4) != 0);
        w.time_synced       = ($urandom_range(0, 2) == 0);
        w.queue_flush_ok    = 1'($urandom_range(0, 1));
        return w;
    endfunction

    task automatic compare_field(input string name, input logic [3:0] want,
                                 input logic [3:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            errors++;
        end
    endtask

    task automatic check_word(input t_out_word want, input t_out_word got);
        compare_field("conn_state", want.conn_state, got.conn_state);
        compare_field("do_link_restart", 4'(want.do_link_restart),
                      4'(got.do_link_restart));
        compare_field("do_link_reconnect", 4'(want.do_link_reconnect),
                      4'(got.do_link_reconnect));
        compare_field("do_link_announce", 4'(want.do_link_announce),
                      4'(got.do_link_announce));
        compare_field("do_time_request", 4'(want.do_time_request),
                      4'(got.do_time_request));
        compare_field("do_firmware_check", 4'(want.do_firmware_check),
                      4'(got.do_firmware_check));
        compare_field("do_broker_begin", 4'(want.do_broker_begin),
                      4'(got.do_broker_begin));
        compare_field("do_publish_announcements", 4'(want.do_publish_announcements),
                      4'(got.do_publish_announcements));
        compare_field("do_announce_ready", 4'(want.do_announce_ready),
                      4'(got.do_announce_ready));
        compare_field("do_service_queues", 4'(want.do_service_queues),
                      4'(got.do_service_queues));
    endtask

    always @(posedge i_clk) begin
        t_out_word pred;
        t_tag      tag;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (want_q.size() == 0) begin
                $error("unexpected result word, conn_state %0d", o_out_data.conn_state);
                errors++;
            end else begin
                check_word(want_q.pop_front(), o_out_data);
            end
        end
        if (i_rst_n && i_in_valid && !o_in_stall) begin
            pred = supervise_poll(i_in_data);
            tag = pend_q.pop_front();
            want_q.push_back(tag.typed ? tag.want : pred);
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial begin
        forever begin
            @(negedge i_clk);
            if (hold_long) begin
                i_out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge i_clk);
                hold_long = 1'b0;
                i_out_stall <= 1'b0;
            end else if (idle_on && $urandom_range(0, 3) == 0) begin
                i_out_stall <= 1'b1;
                repeat ($urandom_range(1, 4)) @(negedge i_clk);
                i_out_stall <= 1'b0;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    task automatic send_word(input t_in_word w, input bit typed, input t_out_word want);
        t_tag tag;
        tag.typed = typed;
        tag.want = want;
        pend_q.push_back(tag);
        if (idle_on && $urandom_range(0, 3) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data <= w;
        @(posedge i_clk);
        while (o_in_stall) @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic wait_drained();
        while (pend_q.size() != 0 || want_q.size() != 0) @(negedge i_clk);
        repeat (DRAIN_CYCLES) @(negedge i_clk);
    endtask

    task automatic program_regs(input t_cfg c);
        i_cfg_we <= 1'b1;
        i_cfg_idx <= CFG_INITIAL_LINK_WAIT;
        i_cfg_wdata <= c.initial_link_wait_us;
        @(negedge i_clk);
        i_cfg_idx <= CFG_RECONNECT_LINK_WAIT;
        i_cfg_wdata <= c.reconnect_link_wait_us;
        @(negedge i_clk);
        i_cfg_idx <= CFG_TIME_SYNC_WAIT;
        i_cfg_wdata <= c.time_sync_wait_us;
        @(negedge i_clk);
        i_cfg_idx <= CFG_BROKER_RETRY_WAIT;
        i_cfg_wdata <= c.broker_retry_wait_us;
        @(negedge i_clk);
        i_cfg_idx <= CFG_MAX_LINK_FAILURES;
        i_cfg_wdata <= {24'($urandom), c.max_link_failures};
        @(negedge i_clk);
        i_cfg_idx <= CFG_ANNOUNCE_INTERVAL;
        i_cfg_wdata <= c.announce_interval_ms;
        @(negedge i_clk);
        // drop: spare index must leave every register alone
        i_cfg_idx <= CFG_IDX_SPARE;
        i_cfg_wdata <= $urandom;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sup_cfg = c;
    endtask

    task automatic run_phase(input t_cfg c, input int n, input int lp, input int np,
                             input bit idle, input int hold_at);
        wait_drained();
        program_regs(c);
        idle_on = idle;
        link_pct = lp;
        noise_pct = np;
        for (int i = 0; i < n; i++) begin
            if (i == hold_at) hold_long = 1'b1;
            send_word(random_poll(), 1'b0, '0);
        end
        i_in_valid <= 1'b0;
    endtask

    task automatic add_row(input t_in_word w, input bit typed, input t_out_word want);
        t_row row;
        row.w = w;
        row.typed = typed;
        row.want = want;
        dir_tbl.push_back(row);
    endtask

    initial begin
        logic [31:0] t0;
        logic [31:0] t_late;
        t0 = 32'hFFFF_FFF0;
        t_late = t0 + RST_INITIAL_LINK_WAIT + 32'd1;

        sup_cfg = {RST_INITIAL_LINK_WAIT, RST_RECONNECT_LINK_WAIT, RST_TIME_SYNC_WAIT,
                   RST_BROKER_RETRY_WAIT, RST_MAX_LINK_FAILURES, RST_ANNOUNCE_INTERVAL};
        sup_ctx = '0;
        sup_ctx.state = ST_INIT;
        sup_ctx.active_link_wait = RST_INITIAL_LINK_WAIT;

        // link attempts wrap the microsecond clock, then exhaust the failure budget
        add_row(poll(t0, 32'd0, F_NONE), 1'b1, result(ST_LINKING, DO_RESTART));
        add_row(poll(t0 + RST_INITIAL_LINK_WAIT, 32'd1, F_NONE), 1'b1,
                result(ST_LINKING, DO_NONE));
        add_row(poll(t_late, 32'd2, F_NONE), 1'b1, result(ST_DOWN, DO_NONE));
        add_row(poll(t_late, 32'd3, F_NONE), 1'b1, result(ST_LINKING, DO_RECONNECT));
        add_row(poll(t_late, 32'd4, F_NONE), 1'b1, result(ST_DOWN, DO_NONE));
        add_row(poll(t_late, 32'd5, F_NONE), 1'b1, result(ST_LINKING, DO_RECONNECT));
        add_row(poll(t_late, 32'd6, F_NONE), 1'b1, result(ST_DOWN, DO_NONE));
        add_row(poll(t_late, 32'd7, F_NONE), 1'b1, result(ST_LINKING, DO_RECONNECT));
        add_row(poll(t_late, 32'd8, F_NONE), 1'b1, result(ST_INIT, DO_NONE));
        add_row(poll(32'd100, 32'd10, F_REINIT), 1'b1, result(ST_LINKING, DO_RESTART));
        add_row(poll(32'd200, 32'd11, F_LINK), 1'b1, result(ST_LINKED, DO_ANNOUNCE));
        // time sync: timeout edge, then retry and success
        add_row(poll(32'd300, 32'd12, F_LINK), 1'b0, '0);
        add_row(poll(32'd1000, 32'd13, F_LINK), 1'b0, '0);
        add_row(poll(32'd1000 + RST_TIME_SYNC_WAIT, 32'd14, F_LINK), 1'b0, '0);
        add_row(poll(32'd1001 + RST_TIME_SYNC_WAIT, 32'd15, F_LINK), 1'b0, '0);
        add_row(poll(32'd2000, 32'd16, F_LINK), 1'b0, '0);
        add_row(poll(32'd2001, 32'd17, F_LINK | F_SYNCED), 1'b0, '0);
        add_row(poll(32'd2002, 32'd18, F_LINK), 1'b0, '0);
        // broker: retry edge, then session up
        add_row(poll(32'd5000, 32'd19, F_LINK), 1'b0, '0);
        add_row(poll(32'd5001, 32'd20, F_LINK), 1'b0, '0);
        add_row(poll(32'd4999 + RST_BROKER_RETRY_WAIT, 32'd21, F_LINK), 1'b0, '0);
        add_row(poll(32'd5000 + RST_BROKER_RETRY_WAIT, 32'd22, F_LINK), 1'b0, '0);
        add_row(poll(32'd8000, 32'd23, F_LINK), 1'b0, '0);
        add_row(poll(32'd8001, 32'd24, F_LINK | F_BROKER), 1'b0, '0);
        add_row(poll(32'd8002, 32'd0, F_LINK | F_BROKER), 1'b1,
                result(ST_READY, DO_PUBLISH | DO_READY));
        add_row(poll(32'd8003, 32'hFFFF_FFFF, F_LINK | F_BROKER | F_FLUSH), 1'b1,
                result(ST_READY, DO_SERVICE));
        add_row(poll(32'd8004, 32'd1, F_LINK), 1'b1, result(ST_LINKREADY, DO_NONE));
        add_row(poll(32'd8005, 32'd2, F_NONE), 1'b1, result(ST_DOWN, DO_NONE));

        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_tbl[k]) send_word(dir_tbl[k].w, dir_tbl[k].typed, dir_tbl[k].want);
        i_in_valid <= 1'b0;
        clk_us = 32'd8005;
        clk_ms = 32'd2;

        run_phase('{32'd50, 32'd20, 32'd30, 32'd10, 8'd3, 32'd100}, 350, 90, 10, 1'b1, -1);
        run_phase('0, 250, 80, 10, 1'b1, -1);
        run_phase('1, 250, 90, 10, 1'b1, 100);
        run_phase('{32'd5, 32'd5, 32'd30, 32'd10, 8'd255, 32'd100}, 560, 0, 0, 1'b1, -1);
        run_phase({$urandom, $urandom, $urandom, $urandom, 8'($urandom), $urandom},
                  150, 85, 10, 1'b1, -1);
        run_phase({RST_INITIAL_LINK_WAIT, RST_RECONNECT_LINK_WAIT, RST_TIME_SYNC_WAIT,
                   RST_BROKER_RETRY_WAIT, RST_MAX_LINK_FAILURES, RST_ANNOUNCE_INTERVAL},
                  200, 90, 10, 1'b0, -1);
        wait_drained();

        if (errors == 0) begin
            $display("Testbench completed without errors");
        end else begin
            $display("Testbench completed WITH ERRORS");
        end
        $finish;
    end

endmodule
